[sv/clrp_pkg.sv]
// Shared types and constants for the card reader link protocol core.
// Used by clrp_front, clrp_queue, clrp_back and the top level; no dependencies.
package clrp_pkg;

	// Queue between the front and back parts, in entries
	localparam int QUEUE_DEPTH = 4;
	// Most results one input item can cause
	localparam int MAX_RESULTS = 5;

	// Input opcodes
	localparam logic [1:0] OP_START   = 2'd0;
	localparam logic [1:0] OP_PAYLOAD = 2'd1;
	localparam logic [1:0] OP_RX_BYTE = 2'd2;
	localparam logic [1:0] OP_TICK    = 2'd3;

	// Result kinds
	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_RX     = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BCC_ERR = 2'd1;
	localparam logic [1:0] ST_ACK_TO  = 2'd2;
	localparam logic [1:0] ST_RESP_TO = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] REG_ACK_CODE    = 3'd0;
	localparam logic [2:0] REG_ENQ_CODE    = 3'd1;
	localparam logic [2:0] REG_STX_CODE    = 3'd2;
	localparam logic [2:0] REG_ETX_CODE    = 3'd3;
	localparam logic [2:0] REG_ACK_WAIT    = 3'd4;
	localparam logic [2:0] REG_REPLY_WAIT  = 3'd5;
	localparam logic [2:0] REG_ERROR_LIMIT = 3'd6;

	// Configuration reset values
	localparam logic [7:0]  RST_ACK_CODE    = 8'd6;
	localparam logic [7:0]  RST_ENQ_CODE    = 8'd5;
	localparam logic [7:0]  RST_STX_CODE    = 8'd2;
	localparam logic [7:0]  RST_ETX_CODE    = 8'd3;
	localparam logic [15:0] RST_ACK_WAIT    = 16'd100;
	localparam logic [15:0] RST_REPLY_WAIT  = 16'd300;
	localparam logic [7:0]  RST_ERROR_LIMIT = 8'd3;

	// Link transaction phase
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SEND,
		PH_ACK,
		PH_RESP
	} phase_t;

	// Work handed from the front to the back: cnt results of one kind.
	// Status jobs carry one result with zero byte.
	typedef struct packed {
		logic [2:0]                  cnt;
		logic [1:0]                  kind;
		logic [1:0]                  status;
		logic                        reinit;
		logic [MAX_RESULTS-1:0][7:0] bytes;
	} job_t;

endpackage

[sv/clrp_front.sv]
// Front part: configuration registers, link protocol state and classification
// of each input item into a job of result bytes. Depends on clrp_pkg.
module clrp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          opcode,
	input  logic [7:0]          data_byte,
	input  logic [7:0]          cmd_length,
	input  logic                q_full,
	output logic                push,
	output clrp_pkg::job_t      push_job
);

	// Configuration registers
	logic [7:0]  ack_code_q, enq_code_q, stx_code_q, etx_code_q, err_limit_q;
	logic [15:0] ack_wait_q, reply_wait_q;

	// Protocol state
	clrp_pkg::phase_t phase_q, phase_d;
	logic [7:0]  acc_q, acc_d;
	logic [7:0]  rem_q, rem_d;
	logic [16:0] pos_q, pos_d;
	logic [16:0] len_q, len_d;
	logic [15:0] wait_q, wait_d;
	logic [7:0]  err_q, err_d;
	logic        miss_q, miss_d;

	clrp_pkg::job_t job_d;

	logic        fire;
	logic        start_go, pay_go, send_last;
	logic        ack_look, ack_hit, resp_rx, fwd, resp_done;
	logic        tick_live, timeout, reinit;
	logic [7:0]  rem_dec, acc_rx, err_inc, acc_start, acc_pay;
	logic [16:0] pos_inc, len_new;
	logic [17:0] pos_plus2;
	logic [15:0] wait_inc, wait_lim;

	// Accept whenever the queue has room
	assign in_stall = q_full;
	assign fire     = in_valid & ~q_full;
	assign push     = fire && (job_d.cnt != 3'd0);
	assign push_job = job_d;

	// Classify the item against the current phase
	assign start_go  = (opcode == clrp_pkg::OP_START) && (phase_q == clrp_pkg::PH_IDLE);
	assign pay_go    = (opcode == clrp_pkg::OP_PAYLOAD) && (phase_q == clrp_pkg::PH_SEND);
	assign rem_dec   = rem_q - 8'd1;
	assign send_last = (rem_dec == 8'd0);
	assign acc_start = stx_code_q ^ cmd_length;
	assign acc_pay   = acc_q ^ data_byte;

	assign ack_look  = (opcode == clrp_pkg::OP_RX_BYTE) && (phase_q == clrp_pkg::PH_ACK)
		&& !miss_q;
	assign ack_hit   = ack_look && (data_byte == ack_code_q);
	assign resp_rx   = (opcode == clrp_pkg::OP_RX_BYTE) && (phase_q == clrp_pkg::PH_RESP);

	// Response frame position tracking
	assign acc_rx    = acc_q ^ data_byte;
	assign pos_inc   = pos_q + 17'd1;
	assign pos_plus2 = {1'b0, pos_q} + 18'd2;
	assign fwd       = (pos_q >= 17'd3) && (pos_plus2 < {1'b0, len_q});
	assign resp_done = resp_rx && (pos_inc >= 17'd3) && (pos_inc >= len_new);

	always_comb begin
		if (pos_q == 17'd1) begin
			len_new = {9'd0, data_byte};
		end else if (pos_q == 17'd2) begin
			len_new = {1'b0, len_q[7:0], 8'd0} + {9'd0, data_byte} + 17'd5;
		end else begin
			len_new = len_q;
		end
	end

	// Timeouts and error count
	assign tick_live = (opcode == clrp_pkg::OP_TICK)
		&& ((phase_q == clrp_pkg::PH_ACK) || (phase_q == clrp_pkg::PH_RESP));
	assign wait_inc  = wait_q + 16'd1;
	assign wait_lim  = (phase_q == clrp_pkg::PH_ACK) ? ack_wait_q : reply_wait_q;
	assign timeout   = tick_live && (wait_inc >= wait_lim);
	assign err_inc   = (err_q == 8'hFF) ? err_q : (err_q + 8'd1);
	assign reinit    = (err_inc > err_limit_q);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (start_go) begin
			phase_d = (cmd_length == 8'd0) ? clrp_pkg::PH_ACK : clrp_pkg::PH_SEND;
		end else if (pay_go && send_last) begin
			phase_d = clrp_pkg::PH_ACK;
		end else if (ack_hit) begin
			phase_d = clrp_pkg::PH_RESP;
		end else if (resp_done || timeout) begin
			phase_d = clrp_pkg::PH_IDLE;
		end
	end

	// Job and datapath state
	always_comb begin
		job_d      = '0;
		job_d.kind = clrp_pkg::KIND_TX;
		acc_d      = acc_q;
		rem_d      = rem_q;
		pos_d      = pos_q;
		len_d      = len_q;
		wait_d     = wait_q;
		err_d      = err_q;
		miss_d     = miss_q;
		if (start_go) begin
			job_d.bytes[0] = stx_code_q;
			job_d.bytes[1] = 8'd0;
			job_d.bytes[2] = cmd_length;
			rem_d          = cmd_length;
			acc_d          = acc_start;
			job_d.cnt      = 3'd3;
			if (cmd_length == 8'd0) begin
				job_d.bytes[3] = etx_code_q;
				job_d.bytes[4] = acc_start ^ etx_code_q;
				acc_d          = acc_start ^ etx_code_q;
				job_d.cnt      = 3'd5;
				wait_d         = '0;
				miss_d         = 1'b0;
			end
		end else if (pay_go) begin
			job_d.bytes[0] = data_byte;
			rem_d          = rem_dec;
			acc_d          = acc_pay;
			job_d.cnt      = 3'd1;
			if (send_last) begin
				job_d.bytes[1] = etx_code_q;
				job_d.bytes[2] = acc_pay ^ etx_code_q;
				acc_d          = acc_pay ^ etx_code_q;
				job_d.cnt      = 3'd3;
				wait_d         = '0;
				miss_d         = 1'b0;
			end
		end else if (ack_look) begin
			if (ack_hit) begin
				err_d          = '0;
				job_d.bytes[0] = enq_code_q;
				job_d.cnt      = 3'd1;
				wait_d         = '0;
				pos_d          = '0;
				len_d          = '0;
				acc_d          = '0;
			end else begin
				miss_d = 1'b1;
			end
		end else if (resp_rx) begin
			acc_d = acc_rx;
			len_d = len_new;
			pos_d = pos_inc;
			if (fwd) begin
				job_d.kind     = clrp_pkg::KIND_RX;
				job_d.bytes[0] = data_byte;
				job_d.cnt      = 3'd1;
			end
			if (resp_done) begin
				err_d        = '0;
				job_d.kind   = clrp_pkg::KIND_STATUS;
				job_d.cnt    = 3'd1;
				job_d.status = (acc_rx != 8'd0) ? clrp_pkg::ST_BCC_ERR : clrp_pkg::ST_OK;
				wait_d       = '0;
			end
		end else if (tick_live) begin
			wait_d = wait_inc;
			if (timeout) begin
				err_d        = reinit ? 8'd0 : err_inc;
				job_d.kind   = clrp_pkg::KIND_STATUS;
				job_d.cnt    = 3'd1;
				job_d.status = (phase_q == clrp_pkg::PH_ACK) ? clrp_pkg::ST_ACK_TO
					: clrp_pkg::ST_RESP_TO;
				job_d.reinit = reinit;
				wait_d       = '0;
			end
		end
	end

	// Advance protocol state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= clrp_pkg::PH_IDLE;
			acc_q   <= '0;
			rem_q   <= '0;
			pos_q   <= '0;
			len_q   <= '0;
			wait_q  <= '0;
			err_q   <= '0;
			miss_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			rem_q   <= rem_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			wait_q  <= wait_d;
			err_q   <= err_d;
			miss_q  <= miss_d;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_code_q   <= clrp_pkg::RST_ACK_CODE;
			enq_code_q   <= clrp_pkg::RST_ENQ_CODE;
			stx_code_q   <= clrp_pkg::RST_STX_CODE;
			etx_code_q   <= clrp_pkg::RST_ETX_CODE;
			ack_wait_q   <= clrp_pkg::RST_ACK_WAIT;
			reply_wait_q <= clrp_pkg::RST_REPLY_WAIT;
			err_limit_q  <= clrp_pkg::RST_ERROR_LIMIT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				clrp_pkg::REG_ACK_CODE:    ack_code_q   <= cfg_data[7:0];
				clrp_pkg::REG_ENQ_CODE:    enq_code_q   <= cfg_data[7:0];
				clrp_pkg::REG_STX_CODE:    stx_code_q   <= cfg_data[7:0];
				clrp_pkg::REG_ETX_CODE:    etx_code_q   <= cfg_data[7:0];
				clrp_pkg::REG_ACK_WAIT:    ack_wait_q   <= cfg_data;
				clrp_pkg::REG_REPLY_WAIT:  reply_wait_q <= cfg_data;
				clrp_pkg::REG_ERROR_LIMIT: err_limit_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

[sv/clrp_queue.sv]
// Short job queue between the front and back parts.
// Depends on clrp_pkg for the job type.
module clrp_queue #(
	parameter int DEPTH = clrp_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  clrp_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output clrp_pkg::job_t head,
	output logic           empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	clrp_pkg::job_t entries_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == CntW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	// Move pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : (wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : (rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/clrp_back.sv]
// Back part: expands queued jobs into result transactions, one per cycle while
// out_stall is low, through an output register. Depends on clrp_pkg.
module clrp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  clrp_pkg::job_t head,
	input  logic           empty,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     result_kind,
	output logic [7:0]     out_byte,
	output logic [1:0]     status_code,
	output logic           reinit_link,
	output logic           last
);

	logic       valid_q;
	logic [2:0] idx_q;
	logic [1:0] kind_q, status_q;
	logic [7:0] byte_q;
	logic       reinit_q, last_q;
	logic       load, at_end;

	// Load a new result when the output register is free or being drained
	assign load   = !empty && (!valid_q || !out_stall);
	assign at_end = (idx_q == (head.cnt - 3'd1));
	assign pop    = load && at_end;

	// Control: output valid and result index within the job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_end ? 3'd0 : (idx_q + 3'd1);
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Payload of the output register
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= head.kind;
			byte_q   <= head.bytes[idx_q];
			status_q <= head.status;
			reinit_q <= head.reinit;
			last_q   <= at_end;
		end
	end

	assign out_valid   = valid_q;
	assign result_kind = kind_q;
	assign out_byte    = byte_q;
	assign status_code = status_q;
	assign reinit_link = reinit_q;
	assign last        = last_q;

endmodule

[sv/card_reader_link_protocol_core.sv]
// Top level of the card reader link protocol core (master side).
// Instantiates clrp_front, clrp_queue and clrp_back; depends on clrp_pkg.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------
//   input    | in_valid / in_stall     | opcode, data_byte, cmd_length
//   result   | out_valid / out_stall   | result_kind, out_byte, status_code,
//            |                         | reinit_link, last
//   config   | cfg_write               | cfg_index, cfg_data
//
// The front takes one item per cycle while the job queue has room; each
// item is classified and its protocol state updated in that cycle.
// An item that causes k results (up to five) has them emitted by the back one result
// per cycle while out_stall is low; with the queue ahead of it empty, its first result
// is written into the queue and then loaded into the output register to be presented.
// in_stall rises only when the job queue is full; out_stall holds the output
// register and, through the queue, eventually the input.
// Reset clears the phase, counters, queue and output valid, and loads register defaults.
module card_reader_link_protocol_core #(
	parameter int QUEUE_DEPTH = clrp_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  cmd_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  out_byte,
	output logic [1:0]  status_code,
	output logic        reinit_link,
	output logic        last
);

	logic           q_full, q_empty, q_push, q_pop;
	clrp_pkg::job_t q_in, q_head;

	// Accept and classify items
	clrp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.data_byte  (data_byte),
		.cmd_length (cmd_length),
		.q_full     (q_full),
		.push       (q_push),
		.push_job   (q_in)
	);

	// Buffer jobs between the two parts
	clrp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	// Emit results
	clrp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.empty       (q_empty),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.out_byte    (out_byte),
		.status_code (status_code),
		.reinit_link (reinit_link),
		.last        (last)
	);

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for card_reader_link_protocol_core: random and directed link traffic,
// with every result checked against a cycle-free model of the link master.
// Depends on clrp_pkg and card_reader_link_protocol_core.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 10;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_TICKS = 30;
	localparam int NUM_PHASES   = 8;
	localparam int PHASE_ITEMS  = 30;

	// One result of the block as the checker sees it
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [1:0] status;
		logic       reinit;
		logic       last;
	} link_result_t;

	// Tracks the link master state and the results each accepted transaction owes
	class link_tracker;
		logic [7:0]        ack_code, enq_code, stx_code, etx_code, error_limit;
		logic [15:0]       ack_wait, reply_wait;
		clrp_pkg::phase_t  link_phase;
		logic [7:0]        bcc, send_left, err_cnt;
		logic [16:0]       rx_pos, rx_len;
		logic [15:0]       wait_cnt;
		logic              ack_missed;
		link_result_t      results_due[$];
		int                errors;

		function new();
			ack_code    = clrp_pkg::RST_ACK_CODE;
			enq_code    = clrp_pkg::RST_ENQ_CODE;
			stx_code    = clrp_pkg::RST_STX_CODE;
			etx_code    = clrp_pkg::RST_ETX_CODE;
			ack_wait    = clrp_pkg::RST_ACK_WAIT;
			reply_wait  = clrp_pkg::RST_REPLY_WAIT;
			error_limit = clrp_pkg::RST_ERROR_LIMIT;
			link_phase  = clrp_pkg::PH_IDLE;
			bcc         = 8'h00;
			send_left   = 8'h00;
			err_cnt     = 8'h00;
			rx_pos      = 17'd0;
			rx_len      = 17'd0;
			wait_cnt    = 16'd0;
			ack_missed  = 1'b0;
			errors      = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] value);
			case (idx)
				clrp_pkg::REG_ACK_CODE:    ack_code = value[7:0];
				clrp_pkg::REG_ENQ_CODE:    enq_code = value[7:0];
				clrp_pkg::REG_STX_CODE:    stx_code = value[7:0];
				clrp_pkg::REG_ETX_CODE:    etx_code = value[7:0];
				clrp_pkg::REG_ACK_WAIT:    ack_wait = value;
				clrp_pkg::REG_REPLY_WAIT:  reply_wait = value;
				clrp_pkg::REG_ERROR_LIMIT: error_limit = value[7:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return results_due.size();
		endfunction

		function void emit(logic [1:0] kind, logic [7:0] data, logic [1:0] status, logic reinit);
			link_result_t r;
			r.kind   = kind;
			r.data   = data;
			r.status = status;
			r.reinit = reinit;
			r.last   = 1'b0;
			results_due.push_back(r);
		endfunction

		function void send_tx(logic [7:0] b);
			bcc = bcc ^ b;
			emit(clrp_pkg::KIND_TX, b, clrp_pkg::ST_OK, 1'b0);
		endfunction

		// Append ETX and the check byte, then wait for the acknowledge
		function void close_frame();
			send_tx(etx_code);
			emit(clrp_pkg::KIND_TX, bcc, clrp_pkg::ST_OK, 1'b0);
			link_phase = clrp_pkg::PH_ACK;
			wait_cnt   = 16'd0;
			ack_missed = 1'b0;
		endfunction

		// Count the timeout and request re-init once the limit is passed
		function void give_up(logic [1:0] code);
			logic reinit;
			reinit = 1'b0;
			if (err_cnt != 8'hFF)
				err_cnt = err_cnt + 8'd1;
			if (err_cnt > error_limit) begin
				reinit  = 1'b1;
				err_cnt = 8'h00;
			end
			emit(clrp_pkg::KIND_STATUS, 8'h00, code, reinit);
			link_phase = clrp_pkg::PH_IDLE;
			wait_cnt   = 16'd0;
		endfunction

		function void take_rx(logic [7:0] b);
			if (link_phase == clrp_pkg::PH_ACK) begin
				// only the first byte after the frame is judged
				if (!ack_missed) begin
					if (b == ack_code) begin
						err_cnt = 8'h00;
						emit(clrp_pkg::KIND_TX, enq_code, clrp_pkg::ST_OK, 1'b0);
						link_phase = clrp_pkg::PH_RESP;
						wait_cnt   = 16'd0;
						rx_pos     = 17'd0;
						rx_len     = 17'd0;
						bcc        = 8'h00;
					end else begin
						ack_missed = 1'b1;
					end
				end
			end else if (link_phase == clrp_pkg::PH_RESP) begin
				bcc = bcc ^ b;
				if (rx_pos == 17'd1)
					rx_len = {9'd0, b};
				else if (rx_pos == 17'd2)
					rx_len = {rx_len[7:0], b} + 17'd5;
				else if (rx_pos >= 17'd3 && int'(rx_pos) + 2 < int'(rx_len))
					emit(clrp_pkg::KIND_RX, b, clrp_pkg::ST_OK, 1'b0);
				rx_pos = rx_pos + 17'd1;
				// whole frame seen: judge the check byte
				if (rx_pos >= 17'd3 && rx_pos >= rx_len) begin
					err_cnt = 8'h00;
					emit(clrp_pkg::KIND_STATUS, 8'h00,
						(bcc == 8'h00) ? clrp_pkg::ST_OK : clrp_pkg::ST_BCC_ERR, 1'b0);
					link_phase = clrp_pkg::PH_IDLE;
					wait_cnt   = 16'd0;
				end
			end
		endfunction

		function void take_tick();
			if (link_phase == clrp_pkg::PH_ACK) begin
				wait_cnt = wait_cnt + 16'd1;
				if (wait_cnt >= ack_wait)
					give_up(clrp_pkg::ST_ACK_TO);
			end else if (link_phase == clrp_pkg::PH_RESP) begin
				wait_cnt = wait_cnt + 16'd1;
				if (wait_cnt >= reply_wait)
					give_up(clrp_pkg::ST_RESP_TO);
			end
		endfunction

		// Advance the link state by one accepted transaction and queue its results
		function void note_item(logic [1:0] op, logic [7:0] b, logic [7:0] len);
			int first;
			first = results_due.size();
			case (op)
				clrp_pkg::OP_START: begin
					if (link_phase == clrp_pkg::PH_IDLE) begin
						bcc = 8'h00;
						send_tx(stx_code);
						send_tx(8'h00);
						send_tx(len);
						send_left  = len;
						link_phase = clrp_pkg::PH_SEND;
						if (len == 8'h00)
							close_frame();
					end
				end
				clrp_pkg::OP_PAYLOAD: begin
					if (link_phase == clrp_pkg::PH_SEND) begin
						send_tx(b);
						send_left = send_left - 8'd1;
						if (send_left == 8'h00)
							close_frame();
					end
				end
				clrp_pkg::OP_RX_BYTE: take_rx(b);
				default: take_tick();
			endcase
			if (results_due.size() > first)
				results_due[results_due.size() - 1].last = 1'b1;
		endfunction

		function void compare_field(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
			end
		endfunction

		// Compare one accepted result with the oldest one owed
		function void check_result(logic [1:0] kind, logic [7:0] data, logic [1:0] status,
				logic reinit, logic last_flag);
			link_result_t want;
			if (results_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual kind %0h byte %0h",
					$time, kind, data);
				return;
			end
			want = results_due.pop_front();
			compare_field("result_kind", {6'd0, want.kind}, {6'd0, kind});
			compare_field("out_byte", want.data, data);
			compare_field("status_code", {6'd0, want.status}, {6'd0, status});
			compare_field("reinit_link", {7'd0, want.reinit}, {7'd0, reinit});
			compare_field("last", {7'd0, want.last}, {7'd0, last_flag});
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = clrp_pkg::REG_ACK_CODE;
	logic [15:0] cfg_data = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode = clrp_pkg::OP_TICK;
	logic [7:0]  data_byte = 8'h00;
	logic [7:0]  cmd_length = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  result_kind;
	logic [7:0]  out_byte;
	logic [1:0]  status_code;
	logic        reinit_link;
	logic        last;

	link_tracker tracker = new();
	int unsigned cycle_count = 0;
	int unsigned item_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned noise_pct = 0;
	bit          short_waits = 1'b0;

	card_reader_link_protocol_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.data_byte   (data_byte),
		.cmd_length  (cmd_length),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.out_byte    (out_byte),
		.status_code (status_code),
		.reinit_link (reinit_link),
		.last        (last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Stall the result channel at random
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Sample both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			tracker.note_item(opcode, data_byte, cmd_length);
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(result_kind, out_byte, status_code, reinit_link, last);
	end

	// Drive one transaction, idling first at random; returns at the falling edge after acceptance
	task automatic push_item(input logic [1:0] op, input logic [7:0] b, input logic [7:0] len);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		data_byte  <= b;
		cmd_length <= len;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		item_count++;
	endtask

	task automatic maybe_noise();
		if (noise_pct != 0 && $urandom_range(99) < noise_pct)
			push_item(2'($urandom_range(3)), 8'($urandom_range(255)), 8'($urandom_range(7)));
	endtask

	// Finish whatever exchange is open: pad the command, then run the timers out
	task automatic return_to_idle();
		while (tracker.link_phase != clrp_pkg::PH_IDLE) begin
			if (tracker.link_phase == clrp_pkg::PH_SEND)
				push_item(clrp_pkg::OP_PAYLOAD, 8'($urandom_range(255)),
					8'($urandom_range(255)));
			else
				push_item(clrp_pkg::OP_TICK, 8'($urandom_range(255)),
					8'($urandom_range(255)));
		end
	endtask

	// Send a few ticks that stay below the given wait
	task automatic idle_ticks(input logic [15:0] wait_len);
		int n;
		n = (wait_len > 16'd1) ? int'(wait_len) - 1 : 0;
		if (n > 3)
			n = 3;
		repeat ($urandom_range(n))
			push_item(clrp_pkg::OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
	endtask

	// One command/response exchange; mostly well formed, sometimes broken
	task automatic run_exchange();
		int unsigned cmd_len, rsp_len, variant, cut;
		logic [7:0]  frame[$];
		logic [7:0]  sum;
		cmd_len = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(6);
		rsp_len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
		variant = $urandom_range(9);
		if (!short_waits && variant inside {6, 7, 8})
			variant = 0;

		// command frame
		push_item(clrp_pkg::OP_START, 8'($urandom_range(255)), 8'(cmd_len));
		maybe_noise();
		repeat (cmd_len) begin
			push_item(clrp_pkg::OP_PAYLOAD, 8'($urandom_range(255)), 8'($urandom_range(255)));
			maybe_noise();
		end
		idle_ticks(tracker.ack_wait);

		// acknowledge: missing, refused, or given
		if (variant == 7) begin
			push_item(clrp_pkg::OP_RX_BYTE, tracker.ack_code ^ 8'($urandom_range(1, 255)),
				8'h00);
			push_item(clrp_pkg::OP_RX_BYTE, tracker.ack_code, 8'h00);
		end else if (variant != 6) begin
			push_item(clrp_pkg::OP_RX_BYTE, tracker.ack_code, 8'($urandom_range(255)));
		end

		// response frame, XOR of all bytes zero unless corrupted
		if (variant != 6 && variant != 7) begin
			idle_ticks(tracker.reply_wait);
			frame.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : tracker.stx_code);
			frame.push_back((variant == 8) ? 8'($urandom_range(255)) : 8'h00);
			frame.push_back(8'(rsp_len));
			repeat (rsp_len)
				frame.push_back(8'($urandom_range(255)));
			frame.push_back(tracker.etx_code);
			sum = 8'h00;
			foreach (frame[i])
				sum = sum ^ frame[i];
			if (variant == 9)
				sum = sum ^ 8'($urandom_range(1, 255));
			frame.push_back(sum);
			// truncated responses stop short and rely on the timeout
			cut = (variant == 8) ? $urandom_range(frame.size() - 1) : frame.size();
			for (int i = 0; i < cut; i++) begin
				push_item(clrp_pkg::OP_RX_BYTE, frame[i], 8'($urandom_range(255)));
				maybe_noise();
			end
		end
		return_to_idle();
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [15:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		tracker.set_reg(idx, value);
	endtask

	// Wait for all owed results, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	// Load a register set and an idling mode for one phase of the run
	task automatic configure_phase(input int p);
		logic [7:0]  ack_c, enq_c, stx_c, etx_c, limit;
		logic [15:0] ack_w, reply_w;
		ack_c   = 8'($urandom_range(255));
		enq_c   = 8'($urandom_range(255));
		stx_c   = 8'($urandom_range(255));
		etx_c   = 8'($urandom_range(255));
		ack_w   = 16'($urandom_range(1, 6));
		reply_w = 16'($urandom_range(1, 30));
		limit   = 8'($urandom_range(4));
		case (p)
			0: begin
				ack_c   = 8'h00;
				enq_c   = 8'h00;
				stx_c   = 8'h00;
				etx_c   = 8'h00;
				ack_w   = 16'd0;
				reply_w = 16'd1;
				limit   = 8'd0;
			end
			1: begin
				ack_c   = 8'hFF;
				enq_c   = 8'hFF;
				stx_c   = 8'hFF;
				etx_c   = 8'hFF;
				ack_w   = 16'hFFFF;
				reply_w = 16'hFFFF;
				limit   = 8'd254;
			end
			3: limit = 8'hFF;
			default: ;
		endcase
		put_reg(clrp_pkg::REG_ACK_CODE, {8'h00, ack_c});
		put_reg(clrp_pkg::REG_ENQ_CODE, {8'h00, enq_c});
		put_reg(clrp_pkg::REG_STX_CODE, {8'h00, stx_c});
		put_reg(clrp_pkg::REG_ETX_CODE, {8'h00, etx_c});
		put_reg(clrp_pkg::REG_ACK_WAIT, ack_w);
		put_reg(clrp_pkg::REG_REPLY_WAIT, reply_w);
		put_reg(clrp_pkg::REG_ERROR_LIMIT, {8'h00, limit});
		cfg_write <= 1'b0;

		short_waits = (ack_w <= 16'd64 && reply_w <= 16'd64);
		noise_pct   = short_waits ? 6 : 0;
		case (p % 4)
			0: begin
				send_idle_pct = 0;
				stall_pct     = 0;
			end
			1: begin
				send_idle_pct = 72;
				stall_pct     = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct     = 72;
			end
			default: begin
				send_idle_pct = 29;
				stall_pct     = 29;
			end
		endcase
	endtask

	// Abort a hung run
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int unsigned phase_end;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ignored while idle
		push_item(clrp_pkg::OP_TICK, 8'h00, 8'h00);
		push_item(clrp_pkg::OP_RX_BYTE, 8'hAA, 8'h00);
		push_item(clrp_pkg::OP_PAYLOAD, 8'h55, 8'hFF);
		// empty command emits the whole frame at once
		push_item(clrp_pkg::OP_START, 8'h00, 8'h00);
		// start while busy and payload outside sending are dropped
		push_item(clrp_pkg::OP_START, 8'hFF, 8'hFF);
		push_item(clrp_pkg::OP_PAYLOAD, 8'h12, 8'h00);
		push_item(clrp_pkg::OP_RX_BYTE, clrp_pkg::RST_ACK_CODE, 8'h00);
		// response with an unchecked start byte and one payload byte
		push_item(clrp_pkg::OP_RX_BYTE, 8'h7E, 8'h00);
		push_item(clrp_pkg::OP_RX_BYTE, 8'h00, 8'h00);
		push_item(clrp_pkg::OP_RX_BYTE, 8'h01, 8'h00);
		push_item(clrp_pkg::OP_RX_BYTE, 8'hFF, 8'h00);
		push_item(clrp_pkg::OP_RX_BYTE, clrp_pkg::RST_ETX_CODE, 8'h00);
		push_item(clrp_pkg::OP_RX_BYTE, 8'h83, 8'h00);
		// empty response with a bad check byte
		push_item(clrp_pkg::OP_START, 8'h00, 8'h01);
		push_item(clrp_pkg::OP_PAYLOAD, 8'hA5, 8'h00);
		push_item(clrp_pkg::OP_RX_BYTE, clrp_pkg::RST_ACK_CODE, 8'h00);
		push_item(clrp_pkg::OP_RX_BYTE, clrp_pkg::RST_STX_CODE, 8'h00);
		push_item(clrp_pkg::OP_RX_BYTE, 8'h00, 8'h00);
		push_item(clrp_pkg::OP_RX_BYTE, 8'h00, 8'h00);
		push_item(clrp_pkg::OP_RX_BYTE, clrp_pkg::RST_ETX_CODE, 8'h00);
		push_item(clrp_pkg::OP_RX_BYTE, 8'h00, 8'h00);
		// refused acknowledge, later ACK ignored, then the timeout
		push_item(clrp_pkg::OP_START, 8'h00, 8'h02);
		push_item(clrp_pkg::OP_PAYLOAD, 8'h00, 8'h00);
		push_item(clrp_pkg::OP_PAYLOAD, 8'hFF, 8'h00);
		push_item(clrp_pkg::OP_RX_BYTE, 8'h00, 8'h00);
		push_item(clrp_pkg::OP_RX_BYTE, clrp_pkg::RST_ACK_CODE, 8'h00);
		return_to_idle();
		settle();

		// random exchanges under several register sets and idling modes
		for (int p = 0; p < NUM_PHASES; p++) begin
			configure_phase(p);
			phase_end = item_count + PHASE_ITEMS;
			while (item_count < phase_end)
				run_exchange();
			settle();
		end

		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
